// ----- hw/rtl/otc_pkg.sv -----
package otc_pkg;

  // Width of the oscillator trim word (allowed range 4 to 16).
  localparam int TRIM_BITS = 8;
  localparam int LEN_W     = 16;
  localparam int OUT_TRIM_W = 8;

  localparam logic [TRIM_BITS-1:0] TRIM_MAX = {TRIM_BITS{1'b1}};
  localparam logic [TRIM_BITS-1:0] TOP_BIT  = {1'b1, {(TRIM_BITS-1){1'b0}}};

  localparam logic [LEN_W-1:0] TARGET_RESET = 16'd2356;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_NEIGH  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_FINISHED  = 2'd1,
    ST_IGNORED   = 2'd2
  } status_t;

  // Neighbour slots: trial-1, trial, trial+1.
  localparam logic [1:0] NB_BELOW = 2'd0;
  localparam logic [1:0] NB_SAME  = 2'd1;
  localparam logic [1:0] NB_ABOVE = 2'd2;

  typedef struct packed {
    logic [TRIM_BITS-1:0] trial_trim;
    logic [TRIM_BITS-1:0] step_bit;
    phase_t               phase;
    logic [1:0]           neighbour_index;
    logic [TRIM_BITS-1:0] best_trim;
    logic [LEN_W-1:0]     best_deviation;
    logic [TRIM_BITS-1:0] applied_trim;
  } cal_state_t;

  typedef struct packed {
    logic [TRIM_BITS-1:0] trim;
    logic                 measure_request;
    status_t              status;
  } cal_result_t;

  localparam cal_state_t STATE_RESET = '{
    trial_trim:      '0,
    step_bit:        TOP_BIT,
    phase:           PH_IDLE,
    neighbour_index: NB_BELOW,
    best_trim:       '0,
    best_deviation:  '0,
    applied_trim:    '0
  };

endpackage

// ----- hw/rtl/oscillator_trim_calibrator_core.sv -----
// Oscillator trim calibrator.
// The input channel (in_valid/in_ready) carries one request per item: op 0
// starts a calibration, op 1 delivers the frame length measured with the trim
// value most recently issued. Every accepted request yields exactly one result
// on the output channel (out_valid/out_ready): the trim value to apply, whether
// a measurement with it is wanted, and a status (searching, finished, ignored).
// The search is a successive approximation from the top trim bit down, followed
// by a check of the three neighbours of the found trim.
// The result of a request is registered and shown in the cycle after the request
// is accepted. Throughput is one request per cycle while the receiver takes each
// result; the whole step is a single compare, subtract and select between the
// state registers and the result register. While the receiver stalls, the held
// result stays put and in_ready drops; in_ready rises again in the cycle the
// result is taken, so the next request can be accepted in that same cycle.
// target_length is written through cfg_wr_en/cfg_wr_data and should only be
// changed while no calibration is running.
// Synchronous reset (rst) empties the result register, returns the search to
// idle and loads target_length with 2356.
module oscillator_trim_calibrator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] measured_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  trim_value,
  output logic        measure_request,
  output logic [1:0]  status
);

  otc_pkg::cal_state_t          state;
  otc_pkg::cal_state_t          state_next;
  otc_pkg::cal_result_t         result_next;
  otc_pkg::cal_result_t         result;
  logic [otc_pkg::LEN_W-1:0]    target_length;
  logic                         in_fire;
  logic [otc_pkg::TRIM_BITS+otc_pkg::OUT_TRIM_W-1:0] trim_ext;

  // The result register is free when empty or being drained this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  otc_step u_step (
    .cur             (state),
    .op              (op),
    .measured_length (measured_length),
    .target_length   (target_length),
    .nxt             (state_next),
    .res             (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= otc_pkg::STATE_RESET;
      target_length <= otc_pkg::TARGET_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_length <= cfg_wr_data;
      end
      if (in_fire) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  // The output carries the low bits of the trim word, zero padded if narrower.
  assign trim_ext        = {{otc_pkg::OUT_TRIM_W{1'b0}}, result.trim};
  assign trim_value      = trim_ext[otc_pkg::OUT_TRIM_W-1:0];
  assign measure_request = result.measure_request;
  assign status          = result.status;

`ifndef NO_ASSERTIONS
  // A measurement is requested exactly while the search is still running.
  a_req_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (measure_request == (status == otc_pkg::ST_SEARCHING)))
    else $error("measure_request disagrees with status");

  // A start request always leaves the block in the binary search phase.
  a_start_enters_search: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == otc_pkg::OP_START) |=> (state.phase == otc_pkg::PH_SEARCH))
    else $error("start did not enter search phase");

  // During the binary search there is always a trial bit left to test.
  a_search_has_step: assert property (@(posedge clk) disable iff (rst)
    (state.phase == otc_pkg::PH_SEARCH) |-> (state.step_bit != '0))
    else $error("search phase without a trial bit");

  // A finished result always returns the search to idle.
  a_finish_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && result_next.status == otc_pkg::ST_FINISHED)
      |=> (state.phase == otc_pkg::PH_IDLE))
    else $error("finished result without return to idle");
`endif

endmodule

// ----- hw/rtl/otc_step.sv -----
module otc_step (
  input  otc_pkg::cal_state_t          cur,
  input  logic                         op,
  input  logic [otc_pkg::LEN_W-1:0]    measured_length,
  input  logic [otc_pkg::LEN_W-1:0]    target_length,
  output otc_pkg::cal_state_t          nxt,
  output otc_pkg::cal_result_t         res
);

  logic [otc_pkg::TRIM_BITS-1:0] kept_trim;
  logic [otc_pkg::TRIM_BITS-1:0] step_shift;
  logic [otc_pkg::TRIM_BITS-1:0] cand_trim;
  logic [otc_pkg::LEN_W-1:0]     deviation;
  logic                          better;
  logic [otc_pkg::TRIM_BITS-1:0] best_trim_upd;
  logic [otc_pkg::LEN_W-1:0]     best_dev_upd;
  logic                          below;

  assign below      = measured_length < target_length;
  assign kept_trim  = below ? cur.trial_trim + cur.step_bit : cur.trial_trim;
  assign step_shift = cur.step_bit >> 1;
  assign cand_trim  = cur.trial_trim + otc_pkg::TRIM_BITS'(cur.neighbour_index)
                      - otc_pkg::TRIM_BITS'(1);
  assign deviation  = below ? target_length - measured_length
                            : measured_length - target_length;
  assign better        = deviation < cur.best_deviation;
  assign best_trim_upd = better ? cand_trim : cur.best_trim;
  assign best_dev_upd  = better ? deviation : cur.best_deviation;

  always_comb begin
    nxt                 = cur;
    res.trim            = cur.applied_trim;
    res.measure_request = 1'b0;
    res.status          = otc_pkg::ST_IGNORED;
    if (op == otc_pkg::OP_START) begin
      nxt.trial_trim      = '0;
      nxt.step_bit        = otc_pkg::TOP_BIT;
      nxt.neighbour_index = otc_pkg::NB_BELOW;
      nxt.phase           = otc_pkg::PH_SEARCH;
      nxt.applied_trim    = otc_pkg::TOP_BIT;
      res.trim            = otc_pkg::TOP_BIT;
      res.measure_request = 1'b1;
      res.status          = otc_pkg::ST_SEARCHING;
    end else begin
      unique case (cur.phase)
        otc_pkg::PH_SEARCH: begin
          nxt.trial_trim      = kept_trim;
          nxt.step_bit        = step_shift;
          res.measure_request = 1'b1;
          res.status          = otc_pkg::ST_SEARCHING;
          if (step_shift != '0) begin
            nxt.applied_trim = kept_trim + step_shift;
          end else begin
            // The raw measured length seeds the best deviation.
            nxt.best_trim      = kept_trim;
            nxt.best_deviation = measured_length;
            nxt.phase          = otc_pkg::PH_NEIGH;
            if (kept_trim != '0) begin
              nxt.neighbour_index = otc_pkg::NB_BELOW;
              nxt.applied_trim    = kept_trim - otc_pkg::TRIM_BITS'(1);
            end else begin
              nxt.neighbour_index = otc_pkg::NB_SAME;
              nxt.applied_trim    = kept_trim;
            end
          end
          res.trim = nxt.applied_trim;
        end
        otc_pkg::PH_NEIGH: begin
          nxt.best_trim      = best_trim_upd;
          nxt.best_deviation = best_dev_upd;
          if (cur.neighbour_index == otc_pkg::NB_BELOW) begin
            nxt.neighbour_index = otc_pkg::NB_SAME;
            nxt.applied_trim    = cur.trial_trim;
            res.measure_request = 1'b1;
            res.status          = otc_pkg::ST_SEARCHING;
          end else if (cur.neighbour_index == otc_pkg::NB_SAME &&
                       cur.trial_trim != otc_pkg::TRIM_MAX) begin
            nxt.neighbour_index = otc_pkg::NB_ABOVE;
            nxt.applied_trim    = cur.trial_trim + otc_pkg::TRIM_BITS'(1);
            res.measure_request = 1'b1;
            res.status          = otc_pkg::ST_SEARCHING;
          end else begin
            nxt.neighbour_index = otc_pkg::NB_BELOW;
            nxt.phase           = otc_pkg::PH_IDLE;
            nxt.applied_trim    = best_trim_upd;
            res.status          = otc_pkg::ST_FINISHED;
          end
          res.trim = nxt.applied_trim;
        end
        default: begin
          nxt.phase = otc_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/trim_search_checker.sv -----
module trim_search_checker
  import otc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             op,
  input  logic [LEN_W-1:0] measured_length,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [7:0]       trim_value,
  input  logic             measure_request,
  input  logic [1:0]       status,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OUT_TRIM_W-1:0] trim;
    logic                  req;
    status_t               st;
  } trim_result_t;

  trim_result_t         expected_trims[$];
  logic [LEN_W-1:0]     target_len;
  logic [TRIM_BITS-1:0] trial;
  logic [TRIM_BITS-1:0] step_bit;
  logic [TRIM_BITS-1:0] best_trim;
  logic [TRIM_BITS-1:0] applied;
  logic [LEN_W-1:0]     best_dev;
  logic [1:0]           slot;
  phase_t               search_phase;
  int                   fails = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // A neighbour slot is usable only when its trim stays inside the trim range.
  function automatic bit slot_in_range(logic [1:0] s, logic [TRIM_BITS-1:0] t);
    case (s)
      NB_BELOW: return t != '0;
      NB_SAME:  return 1'b1;
      NB_ABOVE: return t != TRIM_MAX;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic logic [TRIM_BITS-1:0] slot_trim(logic [1:0] s,
                                                     logic [TRIM_BITS-1:0] t);
    return t + TRIM_BITS'(s) - TRIM_BITS'(1);
  endfunction

  function automatic trim_result_t make_result(logic [TRIM_BITS-1:0] t, logic req,
                                               status_t st);
    trim_result_t r;
    r.trim = OUT_TRIM_W'(t);
    r.req  = req;
    r.st   = st;
    return r;
  endfunction

  // One step of the calibration search for an accepted request.
  task automatic advance_search(input logic kind, input logic [LEN_W-1:0] len,
                                output trim_result_t r);
    logic [TRIM_BITS-1:0] cand;
    logic [LEN_W-1:0]     dev;
    logic [2:0]           nxt;
    if (kind == OP_START) begin
      trial        = '0;
      step_bit     = TOP_BIT;
      slot         = NB_BELOW;
      search_phase = PH_SEARCH;
      applied      = trial + step_bit;
      r = make_result(applied, 1'b1, ST_SEARCHING);
    end else if (search_phase == PH_SEARCH) begin
      if (len < target_len) trial = trial + step_bit;
      step_bit = step_bit >> 1;
      if (step_bit != '0) begin
        applied = trial + step_bit;
        r = make_result(applied, 1'b1, ST_SEARCHING);
      end else begin
        // The raw length of the last binary step seeds the best deviation.
        best_trim    = trial;
        best_dev     = len;
        search_phase = PH_NEIGH;
        slot         = slot_in_range(NB_BELOW, trial) ? NB_BELOW : NB_SAME;
        applied      = slot_trim(slot, trial);
        r = make_result(applied, 1'b1, ST_SEARCHING);
      end
    end else if (search_phase == PH_NEIGH) begin
      cand = slot_trim(slot, trial);
      dev  = (len >= target_len) ? len - target_len : target_len - len;
      if (dev < best_dev) begin
        best_dev  = dev;
        best_trim = cand;
      end
      nxt = {1'b0, slot} + 3'd1;
      if (nxt <= 3'd2 && slot_in_range(nxt[1:0], trial)) begin
        slot    = nxt[1:0];
        applied = slot_trim(slot, trial);
        r = make_result(applied, 1'b1, ST_SEARCHING);
      end else begin
        slot         = NB_BELOW;
        search_phase = PH_IDLE;
        applied      = best_trim;
        r = make_result(applied, 1'b0, ST_FINISHED);
      end
    end else begin
      search_phase = PH_IDLE;
      r = make_result(applied, 1'b0, ST_IGNORED);
    end
  endtask

  always @(posedge clk) begin
    trim_result_t want;
    if (rst) begin
      expected_trims.delete();
      target_len   = TARGET_RESET;
      trial        = '0;
      step_bit     = TOP_BIT;
      search_phase = PH_IDLE;
      slot         = NB_BELOW;
      best_trim    = '0;
      best_dev     = '0;
      applied      = '0;
    end else begin
      // The result leaving now belongs to an earlier request, so it is
      // checked before this edge's request is predicted.
      if (out_valid && out_ready) begin
        if (expected_trims.size() == 0) begin
          $error("result with no request outstanding: trim_value %0d", trim_value);
          fails++;
        end else begin
          want = expected_trims.pop_front();
          if (trim_value !== want.trim) begin
            $error("trim_value mismatch: expected %0d, actual %0d", want.trim, trim_value);
            fails++;
          end
          if (measure_request !== want.req) begin
            $error("measure_request mismatch: expected %0d, actual %0d",
                   want.req, measure_request);
            fails++;
          end
          if (status !== want.st) begin
            $error("status mismatch: expected %0d, actual %0d", want.st, status);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_search(op, measured_length, want);
        expected_trims.push_back(want);
      end
      if (cfg_wr_en) target_len = cfg_wr_data;
    end
    mismatches  <= fails;
    outstanding <= expected_trims.size();
  end

endmodule

// ----- bench/oscillator_trim_calibrator_core_tb.sv -----
module oscillator_trim_calibrator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import otc_pkg::*;

  // The receiver's long hold must stay well below the watchdog limit.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int BURST_MAX      = 18;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 98;

  // Per phase: sender and receiver idle rates in percent, and the target
  // length to program (-1 picks a random one). Phase 0 runs on the reset value.
  localparam int TX_PCT[NUM_PHASES]   = '{15, 0, 30, 10, 40, 20, 15, 0};
  localparam int RX_PCT[NUM_PHASES]   = '{15, 0, 30, 40, 10, 20, 15, 0};
  localparam int TARGETS[NUM_PHASES]  = '{2356, 0, 65535, 1, 65534, -1, -1, 2356};

  logic             clk             = 1'b0;
  logic             rst             = 1'b1;
  logic             cfg_wr_en       = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data     = '0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic             op              = OP_START;
  logic [LEN_W-1:0] measured_length = '0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [7:0]       trim_value;
  logic             measure_request;
  logic [1:0]       status;

  int               mismatches;
  int               outstanding;

  // Stimulus knobs; rx_idle_pct and long_hold are shared with the receiver process.
  int               tx_idle_pct   = 0;
  int               rx_idle_pct   = 0;
  logic             long_hold     = 1'b0;
  int               stuck_cycles  = 0;

  // Trim most recently handed out; feeds the oscillator model of the stimulus.
  logic [7:0]       latest_trim   = '0;
  int               target_now    = TARGET_RESET;

  int               sent_items    = 0;
  int               calibrations  = 0;
  int               cut_short     = 0;
  int               stray_items   = 0;
  int               target_writes = 0;

  always #6 clk = ~clk;

  oscillator_trim_calibrator_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .measured_length (measured_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .trim_value      (trim_value),
    .measure_request (measure_request),
    .status          (status)
  );

  trim_search_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .measured_length (measured_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .trim_value      (trim_value),
    .measure_request (measure_request),
    .status          (status),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  always @(posedge clk) begin
    if (out_valid && out_ready) latest_trim <= trim_value;
  end

  // The watchdog only counts cycles in which neither channel moves a request
  // or a result, so long but legal stalls never trip it.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("oscillator_trim_calibrator_core verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver. It normally takes every result, stalls in random bursts at the
  // current rate, and on demand holds off for a long stretch so that the
  // result register stays full and the block has to stall its input.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idle_pct > 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until the block accepts it. Valid stays
  // high on return unless a random sender gap follows, so back-to-back calls
  // stream requests without dropping valid between them.
  task automatic push_request(input logic kind, input logic [LEN_W-1:0] len);
    in_valid        <= 1'b1;
    op              <= kind;
    measured_length <= len;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_target(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    target_now = value;
    target_writes++;
  endtask

  // A crude oscillator: the frame length grows linearly with the trim and
  // meets the target near a chosen center trim, with a little jitter.
  function automatic logic [LEN_W-1:0] frame_length(logic [7:0] trim, int center,
                                                    int slope);
    int len;
    len = target_now + (int'(trim) - center) * slope + int'($urandom_range(0, 6)) - 3;
    if (len < 0) len = 0;
    if (len > 65535) len = 65535;
    return LEN_W'(len);
  endfunction

  // A well-formed calibration: a start and then one measurement per
  // requested trim. Eleven measurements cover eight search steps and three
  // neighbours; when a neighbour is skipped at an edge, the last one lands
  // on an idle block and is ignored. A paced run waits for each trim before
  // measuring it, a streamed run measures with whatever trim was last seen.
  task automatic run_calibration(input bit paced);
    int center;
    int slope;
    center = $urandom_range(0, 255);
    slope  = $urandom_range(1, 40);
    push_request(OP_START, LEN_W'($urandom));
    for (int i = 0; i < 11; i++) begin
      if (paced) wait_for_results();
      push_request(OP_MEASURE, frame_length(latest_trim, center, slope));
    end
    calibrations++;
  endtask

  initial begin
    int  pick;
    int  budget;
    int  count;
    bit  paused;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset target: a measurement while idle, a start
    // while busy, a search that keeps every bit and ends at the top trim
    // (neighbour above skipped), and a search that keeps none and ends at
    // trim zero (neighbour below skipped). Lengths reach 0 and 65535.
    push_request(OP_MEASURE, 16'd0);
    push_request(OP_START, 16'hFFFF);
    push_request(OP_MEASURE, 16'd0);
    push_request(OP_START, 16'd0);
    repeat (8) push_request(OP_MEASURE, 16'd0);
    push_request(OP_MEASURE, 16'hFFFF);
    push_request(OP_MEASURE, TARGET_RESET);
    push_request(OP_START, 16'h5555);
    repeat (8) push_request(OP_MEASURE, 16'hFFFF);
    push_request(OP_MEASURE, TARGET_RESET);
    push_request(OP_MEASURE, 16'd2000);
    wait_for_results();

    // Random part, in phases; each phase after the first programs a new target
    // length while the block is drained, including both extremes of the register.
    paused = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_for_results();
        write_target(TARGETS[p] < 0 ? int'($urandom_range(200, 65000)) : TARGETS[p]);
      end
      tx_idle_pct = TX_PCT[p];
      rx_idle_pct <= RX_PCT[p];
      if (p == 2) begin
        // Long receiver hold while the sender streams a calibration into it.
        long_hold <= 1'b1;
        tx_idle_pct = 0;
        run_calibration(1'b0);
        tx_idle_pct = TX_PCT[p];
      end
      budget = sent_items + PHASE_ITEMS;
      while (sent_items < budget) begin
        if (p == 5 && !paused && sent_items > budget - PHASE_ITEMS / 2) begin
          // Sender pauses until the block has delivered everything.
          wait_for_results();
          paused = 1'b1;
        end
        pick = $urandom_range(1, 100);
        if (pick <= 70) begin
          run_calibration($urandom_range(0, 1));
        end else if (pick <= 85) begin
          // Broken sequence: the next start restarts the search mid-way.
          push_request(OP_START, LEN_W'($urandom));
          count = $urandom_range(0, 9);
          repeat (count) push_request(OP_MEASURE, LEN_W'($urandom));
          cut_short++;
        end else begin
          count = $urandom_range(1, 4);
          repeat (count) begin
            push_request($urandom_range(0, 3) != 0 ? OP_MEASURE : OP_START,
                         LEN_W'($urandom));
          end
          stray_items += count;
        end
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);

    $display("Run covered %0d requests: %0d full calibrations, %0d cut short, %0d stray.",
             sent_items, calibrations, cut_short, stray_items);
    $display("Target length programmed %0d times, extremes included; one %0d-cycle hold.",
             target_writes, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("oscillator_trim_calibrator_core verification clean");
    end else begin
      $display("oscillator_trim_calibrator_core verification failed");
    end
    $finish;
  end

endmodule
